FILE: hw/rtl/radix_digit_decomposer_macros.svh
// Assertion macros for the radix digit decomposer.
`ifndef RADIX_DIGIT_DECOMPOSER_MACROS_SVH
`define RADIX_DIGIT_DECOMPOSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RDD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RDD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rdd_pkg.sv
// Shared types and constants of the radix digit decomposer.
`default_nettype none

package rdd_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int RADIX_WIDTH_DEF = 32;
  localparam int DIGIT_WIDTH     = 32;
  localparam int POS_WIDTH       = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MSET,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic next_digit;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic last;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rdd_ctrl.sv
// Sequencer of the radix digit decomposer: divide, multiply, emit per digit.
`default_nettype none

module rdd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  rdd_pkg::status_t status_i,
  output rdd_pkg::cmd_t   cmd_o,
  output logic            busy_o,
  output logic            valid_o
);

  rdd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rdd_pkg::ST_IDLE: begin
        if (start_i) state_d = rdd_pkg::ST_DIV;
      end
      rdd_pkg::ST_DIV: begin
        if (status_i.cnt_zero) state_d = rdd_pkg::ST_MSET;
      end
      rdd_pkg::ST_MSET: begin
        state_d = rdd_pkg::ST_MUL;
      end
      rdd_pkg::ST_MUL: begin
        if (status_i.cnt_zero) state_d = rdd_pkg::ST_EMIT;
      end
      rdd_pkg::ST_EMIT: begin
        state_d = status_i.last ? rdd_pkg::ST_IDLE : rdd_pkg::ST_DIV;
      end
      default: begin
        state_d = rdd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    busy_o  = 1'b1;
    valid_o = 1'b0;
    case (state_q)
      rdd_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      rdd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      rdd_pkg::ST_MSET: begin
        cmd_o.mul_init = 1'b1;
      end
      rdd_pkg::ST_MUL: begin
        cmd_o.mul_step = 1'b1;
      end
      rdd_pkg::ST_EMIT: begin
        valid_o          = 1'b1;
        cmd_o.next_digit = !status_i.last;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rdd_datapath.sv
// Datapath: bit-serial restoring divider and shift-add multiplier for term and power.
`default_nettype none

module rdd_datapath #(
  parameter int VALUE_WIDTH = rdd_pkg::VALUE_WIDTH_DEF,
  parameter int RADIX_WIDTH = rdd_pkg::RADIX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rdd_pkg::cmd_t                   cmd_i,
  output rdd_pkg::status_t                status_o,
  input  logic [VALUE_WIDTH-1:0]          value_i,
  input  logic [RADIX_WIDTH-1:0]          radix_i,
  output logic [rdd_pkg::DIGIT_WIDTH-1:0] digit_o,
  output logic [rdd_pkg::POS_WIDTH-1:0]   position_o,
  output logic [VALUE_WIDTH-1:0]          term_o,
  output logic                            nonzero_o,
  output logic                            last_o
);

  localparam int CntMax   = (VALUE_WIDTH > RADIX_WIDTH) ? VALUE_WIDTH : RADIX_WIDTH;
  localparam int CntWidth = $clog2(CntMax);
  localparam logic [CntWidth-1:0] DivLoad = CntWidth'(VALUE_WIDTH - 1);
  localparam logic [CntWidth-1:0] MulLoad = CntWidth'(RADIX_WIDTH - 1);

  logic [CntWidth-1:0]             cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0]          quot_q, quot_d;
  logic [RADIX_WIDTH-1:0]          rem_q, rem_d;
  logic [RADIX_WIDTH-1:0]          radix_q, radix_d;
  logic [VALUE_WIDTH-1:0]          power_q, power_d;
  logic [rdd_pkg::POS_WIDTH-1:0]   pos_q, pos_d;
  logic [VALUE_WIDTH-1:0]          mcand_q, mcand_d;
  logic [VALUE_WIDTH-1:0]          acct_q, acct_d;
  logic [VALUE_WIDTH-1:0]          accp_q, accp_d;
  logic [RADIX_WIDTH-1:0]          dsh_q, dsh_d;
  logic [RADIX_WIDTH-1:0]          rsh_q, rsh_d;

  logic [RADIX_WIDTH:0]            trial;
  logic [RADIX_WIDTH:0]            diff;
  logic                            fits;
  logic [RADIX_WIDTH-1:0]          radix_clamped;

  assign radix_clamped = (radix_i[RADIX_WIDTH-1:1] == '0) ? RADIX_WIDTH'(2) : radix_i;

  assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, radix_q};
  assign fits  = (trial >= {1'b0, radix_q});

  always_comb begin
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    power_d = power_q;
    pos_d   = pos_q;
    mcand_d = mcand_q;
    acct_d  = acct_q;
    accp_d  = accp_q;
    dsh_d   = dsh_q;
    rsh_d   = rsh_q;
    if (cmd_i.load) begin
      quot_d  = value_i;
      rem_d   = '0;
      radix_d = radix_clamped;
      power_d = VALUE_WIDTH'(1);
      pos_d   = '0;
      cnt_d   = DivLoad;
    end
    if (cmd_i.div_step) begin
      rem_d  = fits ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
      quot_d = {quot_q[VALUE_WIDTH-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
    end
    if (cmd_i.mul_init) begin
      mcand_d = power_q;
      acct_d  = '0;
      accp_d  = '0;
      dsh_d   = rem_q;
      rsh_d   = radix_q;
      cnt_d   = MulLoad;
    end
    if (cmd_i.mul_step) begin
      acct_d  = acct_q + (dsh_q[0] ? mcand_q : '0);
      accp_d  = accp_q + (rsh_q[0] ? mcand_q : '0);
      mcand_d = {mcand_q[VALUE_WIDTH-2:0], 1'b0};
      dsh_d   = dsh_q >> 1;
      rsh_d   = rsh_q >> 1;
      cnt_d   = cnt_q - 1'b1;
    end
    if (cmd_i.next_digit) begin
      rem_d   = '0;
      power_d = accp_q;
      pos_d   = pos_q + 1'b1;
      cnt_d   = DivLoad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    power_q <= power_d;
    pos_q   <= pos_d;
    mcand_q <= mcand_d;
    acct_q  <= acct_d;
    accp_q  <= accp_d;
    dsh_q   <= dsh_d;
    rsh_q   <= rsh_d;
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.last     = (quot_q == '0);

  assign digit_o    = rdd_pkg::DIGIT_WIDTH'(rem_q);
  assign position_o = pos_q;
  assign term_o     = acct_q;
  assign nonzero_o  = (rem_q != '0);
  assign last_o     = (quot_q == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/radix_digit_decomposer.sv
// Radix digit decomposer: splits a number into its digits in a given base.
//
// A request is taken at a rising edge with start_i high and busy_o low; it
// carries value_i and radix_i (a radix of 0 or 1 counts as 2). The block then
// emits one result per digit, least significant first: digit, position, the
// term digit * radix^position, a nonzero mark and a last flag. Each result is
// on the outputs for one cycle with valid_o high; the receiver cannot stall.
// Zero yields a single zero digit with last set.
// For each digit the block runs the restoring divider, one quotient bit per
// cycle, then a setup state, then the shift-add multiplier that forms the
// term and the next power, one radix bit per cycle, then an output state.
// A request keeps busy_o high through its last result, and busy_o falls in
// the cycle after the last result. One request is in flight at a time.
// Reset returns the sequencer to idle; no result is pending after reset.
`default_nettype none

`include "radix_digit_decomposer_macros.svh"

module radix_digit_decomposer #(
  parameter int VALUE_WIDTH = rdd_pkg::VALUE_WIDTH_DEF,
  parameter int RADIX_WIDTH = rdd_pkg::RADIX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [VALUE_WIDTH-1:0]          value_i,
  input  logic [RADIX_WIDTH-1:0]          radix_i,
  output logic                            valid_o,
  output logic [rdd_pkg::DIGIT_WIDTH-1:0] digit_o,
  output logic [rdd_pkg::POS_WIDTH-1:0]   position_o,
  output logic [VALUE_WIDTH-1:0]          term_o,
  output logic                            nonzero_o,
  output logic                            last_o
);

  rdd_pkg::cmd_t    cmd;
  rdd_pkg::status_t status;

  rdd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .valid_o  (valid_o)
  );

  rdd_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .RADIX_WIDTH (RADIX_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .value_i    (value_i),
    .radix_i    (radix_i),
    .digit_o    (digit_o),
    .position_o (position_o),
    .term_o     (term_o),
    .nonzero_o  (nonzero_o),
    .last_o     (last_o)
  );

  `RDD_ASSERT_IMP(a_valid_busy, valid_o, busy_o, "result outside a request")
  `RDD_ASSERT_NXT(a_valid_pulse, valid_o, !valid_o, "result strobe longer than one cycle")
  `RDD_ASSERT_NXT(a_last_idle, valid_o && last_o, !busy_o, "busy after last digit")
  `RDD_ASSERT_IMP(a_zero_term, valid_o && !nonzero_o, term_o == '0, "zero digit with term")

endmodule

`default_nettype wire

FILE: tb/radix_digit_decomposer_checker.sv
// Checker for the radix digit decomposer: predicts each digit of a request and compares.
module radix_digit_decomposer_checker #(
  parameter int VALUE_WIDTH = rdd_pkg::VALUE_WIDTH_DEF,
  parameter int RADIX_WIDTH = rdd_pkg::RADIX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_o,
  input  logic [VALUE_WIDTH-1:0]          value_i,
  input  logic [RADIX_WIDTH-1:0]          radix_i,
  input  logic                            valid_o,
  input  logic [rdd_pkg::DIGIT_WIDTH-1:0] digit_o,
  input  logic [rdd_pkg::POS_WIDTH-1:0]   position_o,
  input  logic [VALUE_WIDTH-1:0]          term_o,
  input  logic                            nonzero_o,
  input  logic                            last_o,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_o
);

  typedef struct packed {
    logic [rdd_pkg::DIGIT_WIDTH-1:0] digit;
    logic [rdd_pkg::POS_WIDTH-1:0]   position;
    logic [VALUE_WIDTH-1:0]          term;
    logic                            nonzero;
    logic                            last;
  } digit_rec_t;

  digit_rec_t  expected_digits[$];
  int unsigned digit_no       = 0;
  int unsigned mismatch_count = 0;
  int unsigned pending        = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending;

  task automatic report_mismatch(input string msg);
    $display("[%0t] digit check: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Repeated division; the power advances after every digit, the last included.
  task automatic expand_digits(input logic [VALUE_WIDTH-1:0] value,
                               input logic [RADIX_WIDTH-1:0] radix);
    logic [63:0]                   base;
    logic [63:0]                   quot;
    logic [63:0]                   power;
    logic [63:0]                   rem;
    logic [rdd_pkg::POS_WIDTH-1:0] pos;
    digit_rec_t                    rec;
    base  = 64'(radix);
    quot  = 64'(value);
    power = 64'd1;
    pos   = '0;
    if (base < 64'd2) begin
      base = 64'd2;
    end
    do begin
      rem          = quot % base;
      rec.digit    = rem[rdd_pkg::DIGIT_WIDTH-1:0];
      rec.position = pos;
      rec.term     = VALUE_WIDTH'(rem * power);
      rec.nonzero  = (rem != 64'd0);
      rec.last     = (quot / base == 64'd0);
      expected_digits.push_back(rec);
      quot  = quot / base;
      power = power * base;
      pos++;
    end while (!rec.last);
  endtask

  always @(posedge clk_i) begin
    digit_rec_t want;
    if (rst_ni) begin
      if (valid_o) begin
        digit_no++;
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending (digit %0d pos %0d)",
                                    digit_no, digit_o, position_o));
        end else begin
          want = expected_digits.pop_front();
          if (digit_o !== want.digit)
            report_mismatch($sformatf("result %0d digit got %0d exp %0d",
                                      digit_no, digit_o, want.digit));
          if (position_o !== want.position)
            report_mismatch($sformatf("result %0d position got %0d exp %0d",
                                      digit_no, position_o, want.position));
          if (term_o !== want.term)
            report_mismatch($sformatf("result %0d term got %h exp %h",
                                      digit_no, term_o, want.term));
          if (nonzero_o !== want.nonzero)
            report_mismatch($sformatf("result %0d nonzero got %b exp %b",
                                      digit_no, nonzero_o, want.nonzero));
          if (last_o !== want.last)
            report_mismatch($sformatf("result %0d last got %b exp %b",
                                      digit_no, last_o, want.last));
        end
      end
      if (start_i && !busy_o) begin
        expand_digits(value_i, radix_i);
      end
      pending = expected_digits.size();
    end
  end

endmodule

FILE: tb/radix_digit_decomposer_tb.sv
// Top of the radix digit decomposer testbench: clock, reset, requests and verdict.
module radix_digit_decomposer_tb;

  localparam int VW            = rdd_pkg::VALUE_WIDTH_DEF;
  localparam int RW            = rdd_pkg::RADIX_WIDTH_DEF;
  localparam int NUM_RANDOM    = 99;
  localparam int DIGIT_CYCLES  = VW + RW + 2;
  localparam int STALL_LIMIT   = 20 * DIGIT_CYCLES;
  localparam int NUM_DIRECTED  = 21;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [VW-1:0]                   value_i;
  logic [RW-1:0]                   radix_i;
  logic                            valid_o;
  logic [rdd_pkg::DIGIT_WIDTH-1:0] digit_o;
  logic [rdd_pkg::POS_WIDTH-1:0]   position_o;
  logic [VW-1:0]                   term_o;
  logic                            nonzero_o;
  logic                            last_o;
  int unsigned                     mismatch_count;
  int unsigned                     pending_digits;
  int unsigned                     stall_cycles = 0;
  bit                              burst = 1'b0;

  // Edge cases: zero, radix below two, widest radix, 64-digit runs, exact powers.
  logic [VW-1:0] dir_value [NUM_DIRECTED] = '{
    64'd0, 64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8AC7_2304_89E8_0000, 64'd9, 64'd10, 64'd100, 64'h0000_0000_FFFF_FFFE,
    64'hFFFF_FFFE_0000_0001, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'd12345, 64'h0000_0001_0000_0000
  };
  logic [RW-1:0] dir_radix [NUM_DIRECTED] = '{
    32'd10, 32'd0, 32'd1, 32'd2, 32'd0,
    32'd1, 32'hFFFF_FFFF, 32'd3,
    32'd10, 32'd16, 32'd2,
    32'd10, 32'd10, 32'd10, 32'd10, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h8000_0000, 32'h0001_0000
  };

  radix_digit_decomposer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .radix_i    (radix_i),
    .valid_o    (valid_o),
    .digit_o    (digit_o),
    .position_o (position_o),
    .term_o     (term_o),
    .nonzero_o  (nonzero_o),
    .last_o     (last_o)
  );

  radix_digit_decomposer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .value_i          (value_i),
    .radix_i          (radix_i),
    .valid_o          (valid_o),
    .digit_o          (digit_o),
    .position_o       (position_o),
    .term_o           (term_o),
    .nonzero_o        (nonzero_o),
    .last_o           (last_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_digits)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Request held until accepted; the idle gap sometimes starts only once busy drops.
  task automatic issue_request(input logic [VW-1:0] value, input logic [RW-1:0] radix);
    int unsigned idle;
    @(negedge clk_i);
    idle = burst ? 0 : $urandom_range(0, 17);
    if (idle != 0) begin
      start_i = 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        while (busy_o) @(negedge clk_i);
      end
      repeat (idle) @(negedge clk_i);
    end
    start_i = 1'b1;
    value_i = value;
    radix_i = radix;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    logic [VW-1:0] value;
    logic [RW-1:0] radix;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    radix_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      issue_request(dir_value[i], dir_radix[i]);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 16 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      value = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
        0:       value = '0;
        1, 2:    value = value >> $urandom_range(0, 63);
        3:       value = value >> $urandom_range(32, 63);
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0:       radix = RW'($urandom_range(0, 16));
        1:       radix = RW'($urandom_range(17, 1000));
        default: radix = RW'($urandom());
      endcase
      issue_request(value, radix);
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_digits != 0) @(negedge clk_i);
    repeat (2 * DIGIT_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_digits == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: radix_digit_decomposer.f
+incdir+hw/rtl
hw/rtl/rdd_pkg.sv
hw/rtl/rdd_ctrl.sv
hw/rtl/rdd_datapath.sv
hw/rtl/radix_digit_decomposer.sv
tb/radix_digit_decomposer_checker.sv
tb/radix_digit_decomposer_tb.sv
